// ----- hdl/anemometer_pulse_window_speed_core_assert.svh -----
// assertion macros for the pulse window speed core
// expects signals named clk and rst in the scope of each use
`ifndef ANEMOMETER_PULSE_WINDOW_SPEED_CORE_ASSERT_SVH
`define ANEMOMETER_PULSE_WINDOW_SPEED_CORE_ASSERT_SVH
`ifndef SYNTH
`define APWSC_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apwsc check failed");
`define APWSC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apwsc check failed");
`else
`define APWSC_CHECK(label, ante, cons)
`define APWSC_CHECK_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/apwsc_pkg.sv -----
// shared types and constants for the pulse window speed core
// no dependencies
package apwsc_pkg;

  localparam logic [1:0] FN_PULSE = 2'd0;
  localparam logic [1:0] FN_TICK  = 2'd1;
  localparam logic [1:0] FN_LOAD  = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_ONE  = 2'd1;
  localparam logic [1:0] DIR_TWO  = 2'd2;

  localparam logic [1:0] CFG_COUNT_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_SECONDS_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ROWS_IN_USE   = 2'd2;
  localparam logic [1:0] CFG_DUCT_AREA     = 2'd3;

  localparam logic [7:0]  COUNT_LIMIT_RST   = 8'd100;
  localparam logic [15:0] SECONDS_LIMIT_RST = 16'd10;

  localparam int QDEPTH   = 2;
  localparam int DIV_RATE = 24;
  localparam int DIV_LONG = 58;
  localparam int SECS_PER_HOUR = 60 * 60;

  typedef struct packed {
    logic [7:0]  count_limit;
    logic [15:0] seconds_limit;
    logic [4:0]  rows_in_use;
    logic [23:0] duct_area;
  } cfg_t;

  typedef struct packed {
    logic        is_load;
    logic [1:0]  dir;
    logic [7:0]  cnt;
    logic [15:0] el;
    logic [3:0]  row_index;
    logic [23:0] row_rate;
    logic [31:0] row_speed;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

// ----- hdl/apwsc_if.sv -----
// item channels of the pulse window speed core
// no dependencies
interface apwsc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        level_a;
  logic        level_b;
  logic [3:0]  row_index;
  logic [23:0] row_rate;
  logic signed [31:0] row_speed;
  modport source (output valid, func, level_a, level_b, row_index, row_rate, row_speed,
                  input ready);
  modport sink (input valid, func, level_a, level_b, row_index, row_rate, row_speed,
                output ready);
endinterface

interface apwsc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  direction;
  logic [7:0]  pulse_count;
  logic [15:0] elapsed_seconds;
  logic [23:0] rate;
  logic signed [31:0] speed;
  logic        speed_known;
  logic signed [47:0] airflow;
  logic        airflow_known;
  modport source (output valid, direction, pulse_count, elapsed_seconds, rate, speed,
                  speed_known, airflow, airflow_known, input ready);
  modport sink (input valid, direction, pulse_count, elapsed_seconds, rate, speed,
                speed_known, airflow, airflow_known, output ready);
endinterface

// ----- hdl/apwsc_fifo.sv -----
// short job queue between the classifier and the compute engine
// depends on apwsc_pkg
module apwsc_fifo import apwsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);
  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          slots [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] fill;

  assign full  = (fill == CW'(QDEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end
endmodule

// ----- hdl/apwsc_front.sv -----
// accepts items, tracks direction, count and window seconds, queues closes and loads
// depends on apwsc_pkg and apwsc_if
module apwsc_front import apwsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  apwsc_req_if.sink req,
  input  cfg_t cfg,
  input  logic q_full,
  output logic q_push,
  output job_t q_wdata
);
  logic [1:0]  cur_dir;
  logic [7:0]  step_cnt;
  logic [15:0] win_sec;
  logic        take;
  logic [1:0]  to_dir;
  logic [7:0]  cnt_inc;
  logic        closes;

  assign req.ready = !q_full;
  assign take      = req.valid && !q_full;
  assign to_dir    = req.level_a ? DIR_ONE : DIR_TWO;
  assign cnt_inc   = (step_cnt == 8'hFF) ? step_cnt : step_cnt + 8'd1;
  assign closes    = (cnt_inc > cfg.count_limit) || (win_sec > cfg.seconds_limit);

  always_comb begin
    q_wdata.is_load   = (req.func == FN_LOAD);
    q_wdata.dir       = cur_dir;
    q_wdata.cnt       = cnt_inc;
    q_wdata.el        = win_sec;
    q_wdata.row_index = req.row_index;
    q_wdata.row_rate  = req.row_rate;
    q_wdata.row_speed = req.row_speed;
    q_push = 1'b0;
    if (take) begin
      case (req.func)
        FN_LOAD: q_push = 1'b1;
        FN_PULSE: q_push = (req.level_a != req.level_b) && (cur_dir == to_dir) && closes;
        default: q_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_dir  <= DIR_NONE;
      step_cnt <= '0;
      win_sec  <= '0;
    end else if (take) begin
      case (req.func)
        FN_PULSE: begin
          if (req.level_a != req.level_b) begin
            if (cur_dir != to_dir) begin
              cur_dir  <= to_dir;
              step_cnt <= '0;
              win_sec  <= '0;
            end else if (closes) begin
              step_cnt <= '0;
              win_sec  <= '0;
            end else begin
              step_cnt <= cnt_inc;
            end
          end
        end
        FN_TICK: begin
          if (win_sec != 16'hFFFF) begin
            win_sec <= win_sec + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/apwsc_back.sv -----
// compute engine: rate divide, calibration table scan, interpolation, airflow
// depends on apwsc_pkg and apwsc_if
module apwsc_back import apwsc_pkg::*; #(
  parameter int TABLE_ROWS = 16
) (
  input  logic clk,
  input  logic rst,
  input  job_t q_rdata,
  input  logic q_empty,
  output logic q_pop,
  input  cfg_t cfg,
  apwsc_res_if.source res
);
  localparam int IW = $clog2(TABLE_ROWS);
  localparam int CW = $clog2(TABLE_ROWS + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  typedef enum logic [3:0] {
    S_IDLE, S_RATE, S_RD, S_CHK, S_MUL, S_DLD, S_DIV, S_SUM, S_AIR1, S_AIR2, S_OUT
  } state_t;

  state_t state;

  logic [23:0]        t_rate  [TABLE_ROWS];
  logic signed [31:0] t_speed [TABLE_ROWS];
  logic [23:0]        rd_rate;
  logic signed [31:0] rd_speed;
  logic [IW-1:0]      scan_idx;
  logic [IW-1:0]      waddr;
  logic               mem_we;

  logic [NW-1:0] rows_x;
  logic [NW-1:0] n_rows;
  logic [IW-1:0] last_idx;
  logic          few_rows;

  // shared restoring divider
  logic [24:0] dv_rem;
  logic [57:0] dv_quo;
  logic [23:0] dv_den;
  logic [5:0]  dv_cnt;
  logic [24:0] rem_sh;
  logic        ge;
  logic [24:0] rem_nx;

  logic [23:0]        rate_q;
  logic [23:0]        prev_rate;
  logic signed [31:0] prev_speed;
  logic signed [24:0] m_dr;
  logic [23:0]        m_dx;
  logic signed [32:0] m_dy;
  logic signed [31:0] m_y0;
  logic signed [57:0] prod;
  logic               neg;
  logic [54:0]        air_p;

  logic signed [59:0] qs;
  logic signed [59:0] sum;
  logic signed [31:0] sp_sat;
  logic [66:0]        air_q;

  logic signed [24:0] ip_dr;
  logic [23:0]        ip_dx;
  logic signed [32:0] ip_dy;

  logic [1:0]  o_dir;
  logic [7:0]  o_cnt;
  logic [15:0] o_el;
  logic [23:0] o_rate;
  logic signed [31:0] o_speed;
  logic        o_sk;
  logic signed [47:0] o_af;
  logic        o_ak;
  logic        o_valid;

  assign res.valid           = o_valid;
  assign res.direction       = o_dir;
  assign res.pulse_count     = o_cnt;
  assign res.elapsed_seconds = o_el;
  assign res.rate            = o_rate;
  assign res.speed           = o_speed;
  assign res.speed_known     = o_sk;
  assign res.airflow         = o_af;
  assign res.airflow_known   = o_ak;

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign waddr  = IW'(q_rdata.row_index);
  assign mem_we = q_pop && q_rdata.is_load && (int'(q_rdata.row_index) < TABLE_ROWS);

  assign rows_x   = NW'(cfg.rows_in_use);
  assign n_rows   = (rows_x > NW'(TABLE_ROWS)) ? NW'(TABLE_ROWS) : rows_x;
  assign few_rows = (n_rows < NW'(2));
  assign last_idx = IW'(n_rows - NW'(1));

  assign rem_sh = {dv_rem[23:0], dv_quo[57]};
  assign ge     = (rem_sh >= {1'b0, dv_den});
  assign rem_nx = ge ? rem_sh - {1'b0, dv_den} : rem_sh;

  assign ip_dr = $signed({1'b0, rate_q}) - $signed({1'b0, prev_rate});
  assign ip_dx = rd_rate - prev_rate;
  assign ip_dy = 33'(rd_speed) - 33'(prev_speed);

  assign qs  = neg ? -$signed({2'b00, dv_quo}) : $signed({2'b00, dv_quo});
  assign sum = qs + 60'(m_y0);
  always_comb begin
    if (sum > 60'sh0_0000_0000_7FFF_FFFF) begin
      sp_sat = 32'sh7FFF_FFFF;
    end else if (sum < -60'sh0_0000_0000_8000_0000) begin
      sp_sat = -32'sh8000_0000;
    end else begin
      sp_sat = sum[31:0];
    end
  end

  assign air_q = ({12'b0, air_p} * 67'(SECS_PER_HOUR)) >> 16;

  // calibration table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      t_rate[waddr]  <= q_rdata.row_rate;
      t_speed[waddr] <= $signed(q_rdata.row_speed);
    end
    rd_rate  <= t_rate[scan_idx];
    rd_speed <= t_speed[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      o_valid  <= 1'b0;
      scan_idx <= '0;
      dv_cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty && !q_rdata.is_load) begin
            o_dir <= q_rdata.dir;
            o_cnt <= q_rdata.cnt;
            o_el  <= q_rdata.el;
            if (q_rdata.el == '0) begin
              // empty window reports zeros with both flags set
              o_dir   <= DIR_NONE;
              o_rate  <= '0;
              o_speed <= '0;
              o_sk    <= 1'b1;
              o_af    <= '0;
              o_ak    <= 1'b1;
              o_valid <= 1'b1;
              state   <= S_OUT;
            end else begin
              dv_rem <= '0;
              dv_quo <= {q_rdata.cnt, 16'b0, 34'b0};
              dv_den <= {8'b0, q_rdata.el};
              dv_cnt <= 6'(DIV_RATE);
              state  <= S_RATE;
            end
          end
        end
        S_RATE: begin
          if (dv_cnt != '0) begin
            dv_rem <= rem_nx;
            dv_quo <= {dv_quo[56:0], ge};
            dv_cnt <= dv_cnt - 6'd1;
          end else begin
            rate_q <= dv_quo[23:0];
            o_rate <= dv_quo[23:0];
            if (few_rows || dv_quo[23:0] == '0) begin
              o_speed <= '0;
              o_sk    <= 1'b0;
              o_af    <= '0;
              o_ak    <= 1'b0;
              o_valid <= 1'b1;
              state   <= S_OUT;
            end else begin
              scan_idx <= '0;
              state    <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (scan_idx == '0) begin
            prev_rate  <= rd_rate;
            prev_speed <= rd_speed;
            scan_idx   <= IW'(1);
            state      <= S_RD;
          end else if (scan_idx == IW'(1) && rate_q <= rd_rate) begin
            if (rd_rate == '0) begin
              o_speed <= '0;
              o_sk    <= 1'b0;
              o_af    <= '0;
              o_ak    <= 1'b0;
              o_valid <= 1'b1;
              state   <= S_OUT;
            end else begin
              // proportional below the second row
              m_dr  <= $signed({1'b0, rate_q});
              m_dx  <= rd_rate;
              m_dy  <= 33'(rd_speed);
              m_y0  <= '0;
              state <= S_MUL;
            end
          end else if ((rate_q > prev_rate && rate_q <= rd_rate) ||
                       (scan_idx == last_idx && rd_rate > prev_rate)) begin
            m_dr  <= ip_dr;
            m_dx  <= ip_dx;
            m_dy  <= ip_dy;
            m_y0  <= prev_speed;
            state <= S_MUL;
          end else if (scan_idx == last_idx) begin
            // no extrapolation on a falling last segment: speed reported unknown
            o_speed <= '0;
            o_sk    <= 1'b0;
            o_af    <= '0;
            o_ak    <= 1'b0;
            o_valid <= 1'b1;
            state   <= S_OUT;
          end else begin
            prev_rate  <= rd_rate;
            prev_speed <= rd_speed;
            scan_idx   <= scan_idx + IW'(1);
            state      <= S_RD;
          end
        end
        S_MUL: begin
          prod  <= m_dy * m_dr;
          state <= S_DLD;
        end
        S_DLD: begin
          neg    <= prod[57];
          dv_quo <= prod[57] ? 58'(-prod) : 58'(prod);
          dv_rem <= '0;
          dv_den <= m_dx;
          dv_cnt <= 6'(DIV_LONG);
          state  <= S_DIV;
        end
        S_DIV: begin
          if (dv_cnt != '0) begin
            dv_rem <= rem_nx;
            dv_quo <= {dv_quo[56:0], ge};
            dv_cnt <= dv_cnt - 6'd1;
          end else begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          o_speed <= sp_sat;
          o_sk    <= 1'b1;
          if (sp_sat > 32'sd0 && cfg.duct_area != '0) begin
            state <= S_AIR1;
          end else begin
            o_af    <= '0;
            o_ak    <= 1'b0;
            o_valid <= 1'b1;
            state   <= S_OUT;
          end
        end
        S_AIR1: begin
          air_p <= o_speed[30:0] * cfg.duct_area;
          state <= S_AIR2;
        end
        S_AIR2: begin
          if (air_q > 67'h7FFF_FFFF_FFFF) begin
            o_af <= 48'sh7FFF_FFFF_FFFF;
          end else begin
            o_af <= $signed(air_q[47:0]);
          end
          o_ak    <= 1'b1;
          o_valid <= 1'b1;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) begin
            o_valid <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/anemometer_pulse_window_speed_core.sv -----
// Pulse window speed core. Pulse edges, second ticks and calibration row loads
// enter on req; a closed window yields one item on res with direction, count,
// seconds, rate, calibrated speed and airflow. Items that close no window are
// taken while the job queue has room. A closing window runs the rate divide, a
// scan of the calibration rows on the single table read port, then the
// interpolation multiply and 58-step divide and the airflow step, with the queue
// of two jobs letting new items arrive meanwhile. No clearing pass after reset.
// depends on apwsc_pkg, apwsc_if, apwsc_fifo, apwsc_front, apwsc_back
`include "anemometer_pulse_window_speed_core_assert.svh"
module anemometer_pulse_window_speed_core import apwsc_pkg::*; #(
  parameter int TABLE_ROWS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  apwsc_req_if.sink   req,
  apwsc_res_if.source res
);
  cfg_t  cfg;
  logic  q_push;
  logic  q_full;
  job_t  q_wdata;
  job_t  q_rdata;
  logic  q_pop;
  logic  q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_limit   <= COUNT_LIMIT_RST;
      cfg.seconds_limit <= SECONDS_LIMIT_RST;
      cfg.rows_in_use   <= '0;
      cfg.duct_area     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT_LIMIT:   cfg.count_limit   <= cfg_data[7:0];
        CFG_SECONDS_LIMIT: cfg.seconds_limit <= cfg_data[15:0];
        CFG_ROWS_IN_USE:   cfg.rows_in_use   <= cfg_data[4:0];
        CFG_DUCT_AREA:     cfg.duct_area     <= cfg_data;
        default: ;
      endcase
    end
  end

  apwsc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  apwsc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  apwsc_back #(.TABLE_ROWS(TABLE_ROWS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .res     (res)
  );

  `APWSC_CHECK(a_no_overflow, q_push, !q_full)
  `APWSC_CHECK(a_no_pop_empty, q_pop, !q_empty)
  `APWSC_CHECK(a_empty_window, res.valid && res.elapsed_seconds == 16'd0, res.speed_known && res.airflow_known && res.direction == DIR_NONE)
  `APWSC_CHECK(a_unknown_speed, res.valid && !res.speed_known, res.speed == 32'sd0 && !res.airflow_known)
endmodule
